@@ hw/rtl/smr_pkg.sv @@
// Shared types and codes for the stack with middle removal.
`timescale 1ns / 1ps
`default_nettype none

package smr_pkg;

    localparam int WORD_W    = 32;
    localparam int POS_W     = 5;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 6;
    localparam int POS_SPAN  = 1 << POS_W;

    // request codes
    localparam logic [FUNC_W-1:0] FN_PUSH    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REM_POS = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REM_KEY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    // per-cell data moves
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_PUSH = 2'd1; // take word from the cell above
    localparam logic [1:0] CELL_POP  = 2'd2; // take word from the cell below
    localparam logic [1:0] CELL_TAKE = 2'd3; // take from below where the token has hit

    typedef struct packed {
        logic [1:0]        op;
        logic              walk;   // advance the search token one cell
        logic              by_key; // 1: match on key, 0: match on position
        logic [WORD_W-1:0] key;
        logic [POS_W-1:0]  pos;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/stack_with_middle_removal.sv @@
// Top level: bounded LIFO stack with removal from the middle, built as a row of slots.
//
// Usage:
//   Requests enter on the slave stream (s_axis). tuser carries the operation code,
//   tdata carries the value and the position. Each request gives exactly one result
//   on the master stream (m_axis): tuser is the status, tdata the removed word and
//   the entry count after the request.
//   Slot 0 of the row is the top of the stack. Push shifts every slot down by one,
//   pop shifts every slot up by one; both, as well as clear and rejected requests,
//   finish in the accept cycle, so the result shows on the next cycle and, while the
//   receiver takes results, a new request may follow every cycle.
//   Removal by position or by value sends a search token down the row, one slot per
//   cycle. The row is DEPTH slots long; after the token has crossed it and the output
//   register is free, the result is loaded, and along with it the slots at and below
//   the first match move up by one together.
//   The result sits in an output register. While the receiver stalls, the result
//   holds and no further request is taken; a request is taken as soon as the
//   pending result leaves in the same cycle.
//   Reset (synchronous, active low) empties the stack and drops a pending result.
//   Slot words are not cleared; slots beyond the count are never looked at.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_middle_removal
    import smr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] value, [36:32] position, rest zero
    input  wire logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // [31:0] removed_value, [37:32] count
    output logic      [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int IDXW  = $clog2(DEPTH);
    localparam int EXT_W = (CNTW > CNT_OUT_W) ? CNTW : CNT_OUT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state,   n_state;
    logic [CNTW-1:0]   r_count,   n_count;
    logic [IDXW-1:0]   r_walk,    n_walk;
    logic              r_by_key,  n_by_key;
    logic [WORD_W-1:0] r_key,     n_key;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic              r_out_vld, n_out_vld;
    logic [STAT_W-1:0] r_status,  n_status;
    logic [WORD_W-1:0] r_removed, n_removed;

    logic              out_free;
    logic              in_xfer;
    logic              load_result;
    logic              is_full;
    logic              is_empty;
    logic [FUNC_W-1:0] in_func;
    logic [WORD_W-1:0] in_value;
    logic [POS_W-1:0]  in_pos;
    logic [EXT_W-1:0]  count_ext;
    t_cell_ctl         ctl;

    logic [WORD_W-1:0] slot_data [DEPTH];
    logic              tok_hit   [DEPTH];
    logic [WORD_W-1:0] tok_val   [DEPTH];

    assign in_func  = s_axis_tuser;
    assign in_value = s_axis_tdata[WORD_W-1:0];
    assign in_pos   = s_axis_tdata[WORD_W +: POS_W];

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign is_full       = (r_count == CNTW'(DEPTH));
    assign is_empty      = (r_count == '0);

    // request decode and sequencing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_walk      = r_walk;
        n_by_key    = r_by_key;
        n_key       = r_key;
        n_pos       = r_pos;
        n_status    = r_status;
        n_removed   = r_removed;
        load_result = 1'b0;
        ctl.op      = CELL_HOLD;
        ctl.walk    = (r_state == S_WALK);
        ctl.by_key  = r_by_key;
        ctl.key     = r_key;
        ctl.pos     = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    load_result = 1'b1;
                    n_status    = ST_OK;
                    n_removed   = '0;
                    unique case (in_func)
                        FN_PUSH: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                ctl.op  = CELL_PUSH;
                                n_count = r_count + 1'b1;
                            end
                        end
                        FN_POP: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ctl.op    = CELL_POP;
                                n_removed = slot_data[0];
                                n_count   = r_count - 1'b1;
                            end
                        end
                        FN_REM_POS, FN_REM_KEY: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // result comes after the token has crossed the row
                                load_result = 1'b0;
                                n_by_key    = (in_func == FN_REM_KEY);
                                n_key       = in_value;
                                n_pos       = in_pos;
                                n_walk      = '0;
                                n_state     = S_WALK;
                            end
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_status = ST_MISS;
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_walk = r_walk + 1'b1;
                if (r_walk == IDXW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_result = 1'b1;
                    n_state     = S_IDLE;
                    if (tok_hit[DEPTH-1]) begin
                        ctl.op    = CELL_TAKE;
                        n_status  = ST_OK;
                        n_removed = tok_val[DEPTH-1];
                        n_count   = r_count - 1'b1;
                    end else begin
                        n_status  = ST_MISS;
                        n_removed = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_result) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk    <= n_walk;
        r_by_key  <= n_by_key;
        r_key     <= n_key;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    // the row of slots; slot 0 is the top
    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        logic [WORD_W-1:0] above_data;
        logic [WORD_W-1:0] below_data;
        logic              up_hit;
        logic [WORD_W-1:0] up_val;

        if (k == 0) begin : g_top
            assign above_data = in_value;
            assign up_hit     = 1'b0;
            assign up_val     = '0;
        end else begin : g_inner
            assign above_data = slot_data[k-1];
            assign up_hit     = tok_hit[k-1];
            assign up_val     = tok_val[k-1];
        end

        if (k == DEPTH - 1) begin : g_bottom
            assign below_data = slot_data[k];
        end else begin : g_upper
            assign below_data = slot_data[k+1];
        end

        smr_cell #(
            .CNTW (CNTW),
            .IDX  (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_count      (r_count),
            .i_above_data (above_data),
            .i_below_data (below_data),
            .i_tok_hit    (up_hit),
            .i_tok_val    (up_val),
            .o_data       (slot_data[k]),
            .o_tok_hit    (tok_hit[k]),
            .o_tok_val    (tok_val[k])
        );
    end

    // count field carries the low bits of the entry count
    assign count_ext = EXT_W'(r_count);

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, count_ext[CNT_OUT_W-1:0], r_removed};

endmodule

`default_nettype wire

@@ hw/rtl/smr_cell.sv @@
// One stack slot: holds a word and forwards the search token to the next slot.
`timescale 1ns / 1ps
`default_nettype none

module smr_cell
    import smr_pkg::*;
#(
    parameter int CNTW = 6,
    parameter int IDX  = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [CNTW-1:0]   i_count,
    input  wire logic [WORD_W-1:0] i_above_data,
    input  wire logic [WORD_W-1:0] i_below_data,
    input  wire logic              i_tok_hit,
    input  wire logic [WORD_W-1:0] i_tok_val,
    output logic      [WORD_W-1:0] o_data,
    output logic                   o_tok_hit,
    output logic      [WORD_W-1:0] o_tok_val
);

    localparam bit POS_REACH = (IDX < POS_SPAN);

    logic [WORD_W-1:0] r_data;
    logic              r_tok_hit;
    logic [WORD_W-1:0] r_tok_val;
    logic              slot_valid;
    logic              pos_match;
    logic              mark;

    assign slot_valid = CNTW'(IDX) < i_count;
    assign pos_match  = POS_REACH && (i_ctl.pos == POS_W'(IDX));
    assign mark       = slot_valid && (i_ctl.by_key ? (r_data == i_ctl.key) : pos_match);

    // token: hit = some slot at or above this one matched; val = first match word
    always_ff @(posedge i_clk) begin
        if (i_ctl.walk) begin
            r_tok_hit <= i_tok_hit | mark;
            r_tok_val <= i_tok_hit ? i_tok_val : r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            CELL_PUSH: r_data <= i_above_data;
            CELL_POP:  r_data <= i_below_data;
            CELL_TAKE: if (r_tok_hit) r_data <= i_below_data;
            default:   r_data <= r_data;
        endcase
    end

    assign o_data    = r_data;
    assign o_tok_hit = r_tok_hit;
    assign o_tok_val = r_tok_val;

endmodule

`default_nettype wire

@@ hw/rtl/smr_check.sv @@
// Port-level checks for the stack with middle removal, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smr_check
    import smr_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [39:0] s_axis_tdata,
    input wire logic [2:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // full status only at capacity, nothing removed
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
            (m_axis_tdata[37:32] == 6'(DEPTH)) && (m_axis_tdata[31:0] == '0))
        else $error("full status with wrong count or word");

    // empty status leaves an empty stack and removes nothing
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            (m_axis_tdata[37:32] == '0) && (m_axis_tdata[31:0] == '0))
        else $error("empty status with entries or word");

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (DEPTH > 63) || (m_axis_tdata[37:32] <= 6'(DEPTH)))
        else $error("count beyond capacity");

endmodule

bind stack_with_middle_removal smr_check #(.DEPTH(DEPTH)) u_smr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_stack_with_middle_removal.sv @@
// Self-checking testbench for the stack with middle removal.
`timescale 1ns / 1ps

module tb_stack_with_middle_removal;
    import smr_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int N_ITEMS     = 1550;
    localparam int IDLE_PCT    = 18;

    // undefined request codes, answered with a miss
    localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         pos;
        bit                       wait_drain; // hold until all results are back
    } t_stack_req;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] removed;
        logic [CNT_OUT_W-1:0]     count;
    } t_stack_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // [31:0] value, [36:32] position, rest zero
    logic [2:0]  s_axis_tuser = '0;   // [2:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] removed_value, [37:32] count
    logic [1:0]  m_axis_tuser;        // [1:0] status

    t_stack_req  pending_reqs[$];
    t_stack_res  due_results[$];
    t_stack_req  cur_req;
    int          n_sent = 0;
    int          n_errors = 0;

    // shadow of the stack contents, slot 0 is the bottom
    logic signed [WORD_W-1:0] shadow_words[STACK_DEPTH];
    int                       shadow_fill = 0;

    wire calm = (n_sent >= 700) && (n_sent < 1000);

    stack_with_middle_removal #(
        .DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Apply one request to the shadow stack and give the result it must produce.
    task automatic stack_apply(input t_stack_req rq, output t_stack_res rs);
        int idx;
        int i;
        rs.status  = ST_OK;
        rs.removed = '0;
        idx = -1;
        case (rq.func)
            FN_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    shadow_words[shadow_fill] = rq.value;
                    shadow_fill++;
                end
            end
            FN_POP: begin
                if (shadow_fill == 0) rs.status = ST_EMPTY;
                else idx = shadow_fill - 1;
            end
            FN_REM_POS: begin
                if (shadow_fill == 0) rs.status = ST_EMPTY;
                else if (int'(rq.pos) >= shadow_fill) rs.status = ST_MISS;
                else idx = shadow_fill - 1 - int'(rq.pos);
            end
            FN_REM_KEY: begin
                if (shadow_fill == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    // first match counted from the top
                    for (i = shadow_fill - 1; i >= 0 && idx < 0; i--)
                        if (shadow_words[i] == rq.value) idx = i;
                    if (idx < 0) rs.status = ST_MISS;
                end
            end
            FN_CLEAR: shadow_fill = 0;
            default: rs.status = ST_MISS;
        endcase
        if (idx >= 0) begin
            rs.removed = shadow_words[idx];
            for (i = idx; i < shadow_fill - 1; i++) shadow_words[i] = shadow_words[i + 1];
            shadow_fill--;
        end
        rs.count = shadow_fill[CNT_OUT_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
        n_errors++;
    endtask

    function automatic t_stack_req mk_req(input logic [FUNC_W-1:0] func,
                                          input logic signed [WORD_W-1:0] value,
                                          input logic [POS_W-1:0] pos);
        t_stack_req rq;
        rq.func       = func;
        rq.value      = value;
        rq.pos        = pos;
        rq.wait_drain = 1'b0;
        return rq;
    endfunction

    // Mostly a small pool so that key searches hit, some extremes, some full-range words.
    function automatic logic signed [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return WORD_W'(int'($urandom_range(0, 15)) - 8);
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // mode 0 fills, mode 1 drains, mode 2 is balanced
    function automatic logic [FUNC_W-1:0] pick_func(input int mode);
        int r;
        int t_push;
        int t_pop;
        int t_pos;
        int t_key;
        int t_clr;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin t_push = 70; t_pop = 76; t_pos = 86; t_key = 98; t_clr = 99; end
            1: begin t_push = 15; t_pop = 45; t_pos = 70; t_key = 95; t_clr = 97; end
            default: begin t_push = 45; t_pop = 60; t_pos = 78; t_key = 96; t_clr = 98; end
        endcase
        if (r < t_push) return FN_PUSH;
        if (r < t_pop) return FN_POP;
        if (r < t_pos) return FN_REM_POS;
        if (r < t_key) return FN_REM_KEY;
        if (r < t_clr) return FN_CLEAR;
        case ($urandom_range(0, 2))
            0: return FN_RSVD5;
            1: return FN_RSVD6;
            default: return FN_RSVD7;
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        t_stack_req rq;
        int n_made;
        int last_drain;
        int mode;
        int len;

        // directed: empty-stack cases, extremes, key and position removals
        pending_reqs.push_back(mk_req(FN_POP,     $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd0));
        pending_reqs.push_back(mk_req(FN_REM_KEY, 32'sd0, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_CLEAR,   $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_RSVD5,   $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_RSVD7,   $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    32'h7FFF_FFFF, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    32'h8000_0000, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    32'sd5, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    -32'sd1, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    32'sd5, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_REM_KEY, 32'sd5, POS_W'($urandom())));  // duplicate key
        pending_reqs.push_back(mk_req(FN_REM_KEY, 32'sd1234, POS_W'($urandom()))); // absent key
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd4));    // just past count
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd31));
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd3));    // bottom entry
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd1));    // middle entry
        pending_reqs.push_back(mk_req(FN_POP,     $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_RSVD6,   $urandom(), POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_PUSH,    32'sd0, POS_W'($urandom())));
        pending_reqs.push_back(mk_req(FN_CLEAR,   $urandom(), POS_W'($urandom()))); // non-empty
        pending_reqs.push_back(mk_req(FN_POP,     $urandom(), POS_W'($urandom())));
        n_made = pending_reqs.size();

        // fill past full, then take the bottom at full depth
        repeat (STACK_DEPTH + 2)
            pending_reqs.push_back(mk_req(FN_PUSH, pick_word(), POS_W'($urandom())));
        pending_reqs[n_made].wait_drain = 1'b1;
        pending_reqs.push_back(mk_req(FN_REM_POS, $urandom(), 5'd31));
        pending_reqs.push_back(mk_req(FN_REM_KEY, pick_word(), POS_W'($urandom())));
        n_made = pending_reqs.size();
        last_drain = n_made;

        // random bursts biased toward filling, draining or balance
        while (n_made < N_ITEMS) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            repeat (len) begin
                rq = mk_req(pick_func(mode), pick_word(),
                            ($urandom_range(0, 1) != 0) ? POS_W'($urandom_range(0, 7))
                                                        : POS_W'($urandom()));
                if (n_made - last_drain >= 400) begin
                    rq.wait_drain = 1'b1;
                    last_drain = n_made;
                end
                pending_reqs.push_back(rq);
                n_made++;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (STACK_DEPTH + 8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Request driver: record each transfer, then load the next item or idle.
    always @(posedge i_clk) begin
        t_stack_res rs;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                stack_apply(cur_req, rs);
                due_results.push_back(rs);
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0
                        && !(pending_reqs[0].wait_drain && due_results.size() != 0)
                        && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {3'b000, cur_req.pos, cur_req.value};
                    s_axis_tuser  <= cur_req.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_stack_res want;
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with no request pending", m_axis_tdata[31:0], '0);
            end else begin
                want = due_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[31:0] !== want.removed)
                    report_mismatch("removed_value", m_axis_tdata[31:0], want.removed);
                if (m_axis_tdata[37:32] !== want.count)
                    report_mismatch("count", 32'(m_axis_tdata[37:32]), 32'(want.count));
            end
        end
    end

endmodule

@@ files.f @@
hw/rtl/smr_pkg.sv
hw/rtl/smr_cell.sv
hw/rtl/stack_with_middle_removal.sv
hw/rtl/smr_check.sv
tb/tb_stack_with_middle_removal.sv
